### src/dft_pkg.sv
package dft_pkg;

    localparam int TWIDDLE_BITS = 16;
    localparam int BIN_BITS     = 24;
    localparam int PHASE_BITS   = 6;
    localparam int TABLE_SIZE   = 64;
    localparam int OUT_MAX      = 8388607;
    localparam int OUT_MIN      = -8388608;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_EMIT
    } dft_state_t;

    // Control half of a sample token travelling along the row of cells.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tok_ctl_t;

    typedef logic signed [TWIDDLE_BITS-1:0] twiddle_t;
    typedef logic [PHASE_BITS-1:0]          phase_t;

    localparam twiddle_t QUARTER_COS [0:16] = '{
        16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
        16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
        16'sd12540, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
    };

    function automatic twiddle_t cos_at(input phase_t a);
        logic [1:0] q;
        logic [4:0] r;
        logic [4:0] r_mirror;
        twiddle_t   v;
        q        = a[5:4];
        r        = {1'b0, a[3:0]};
        r_mirror = 5'd16 - r;
        unique case (q)
            2'd0:    v = QUARTER_COS[r];
            2'd1:    v = -QUARTER_COS[r_mirror];
            2'd2:    v = -QUARTER_COS[r];
            default: v = QUARTER_COS[r_mirror];
        endcase
        return v;
    endfunction

    function automatic twiddle_t sin_at(input phase_t a);
        phase_t b;
        b = a + phase_t'(48);
        return cos_at(b);
    endfunction

endpackage

### src/dft_idft_engine_top.sv
// The first bin appears once the final sample of a frame has travelled the row of POINTS cells
// and the last cell has flagged its sum finished, which moves the state from calc to emit.
// Throughput: one sample per cycle while loading, then one bin per cycle while emitting
// unless bin_stall holds it; samples are stalled outside loading.
// Reset clears the shared load/emit counter, the state and both direction registers; stored sums need none.
module dft_idft_engine_top #(
    parameter int POINTS      = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_real,
    input  logic signed [SAMPLE_BITS-1:0]       sample_imag,
    output logic                                bin_valid,
    input  logic                                bin_stall,
    output logic signed [dft_pkg::BIN_BITS-1:0] bin_real,
    output logic signed [dft_pkg::BIN_BITS-1:0] bin_imag,
    output logic                                bin_last
);
    import dft_pkg::*;

    localparam int LOG2N  = $clog2(POINTS);
    localparam int STRIDE = TABLE_SIZE / POINTS;

    dft_state_t state_reg, state_next;
    logic [LOG2N-1:0] cnt_reg, cnt_next;
    logic             inv_cfg_reg;
    logic             mode_reg;
    tok_ctl_t         tok_reg;
    logic signed [SAMPLE_BITS-1:0] tok_xr_reg, tok_xi_reg;

    logic sample_acc, bin_acc, shift_en;

    tok_ctl_t                      ctl_w [0:POINTS];
    logic signed [SAMPLE_BITS-1:0] xr_w  [0:POINTS];
    logic signed [SAMPLE_BITS-1:0] xi_w  [0:POINTS];
    logic signed [BIN_BITS-1:0]    rr_w  [0:POINTS];
    logic signed [BIN_BITS-1:0]    ri_w  [0:POINTS];
    logic                          fin_w [0:POINTS-1];

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != ST_LOAD);
    assign sample_acc   = sample_valid & ~sample_stall;
    assign bin_valid    = (state_reg == ST_EMIT);
    assign bin_acc      = bin_valid & ~bin_stall;
    assign shift_en     = bin_acc;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (sample_acc)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LOG2N'(POINTS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (fin_w[POINTS-1])
                    state_next = ST_EMIT;
            end
            default:
            begin
                if (bin_acc)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LOG2N'(POINTS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            inv_cfg_reg <= 1'b0;
            mode_reg    <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid & cfg_ready)
                inv_cfg_reg <= cfg_data;
            // The direction is fixed for the frame when its final sample arrives.
            if (sample_acc && cnt_reg == LOG2N'(POINTS - 1))
                mode_reg <= inv_cfg_reg;
            tok_reg.valid <= sample_acc;
            tok_reg.first <= (cnt_reg == '0);
            tok_reg.last  <= (cnt_reg == LOG2N'(POINTS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            tok_xr_reg <= sample_real;
            tok_xi_reg <= sample_imag;
        end
    end

    assign ctl_w[0]   = tok_reg;
    assign xr_w[0]    = tok_xr_reg;
    assign xi_w[0]    = tok_xi_reg;
    assign rr_w[POINTS] = '0;
    assign ri_w[POINTS] = '0;

    genvar k;
    generate
        for (k = 0; k < POINTS; k++)
        begin : g_cell
            dft_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .LOG2N       (LOG2N),
                .STEP        ((k * STRIDE) % TABLE_SIZE)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_ctl    (ctl_w[k]),
                .in_xr     (xr_w[k]),
                .in_xi     (xi_w[k]),
                .inverse   (mode_reg),
                .shift_en  (shift_en),
                .res_in_r  (rr_w[k+1]),
                .res_in_i  (ri_w[k+1]),
                .out_ctl   (ctl_w[k+1]),
                .out_xr    (xr_w[k+1]),
                .out_xi    (xi_w[k+1]),
                .res_out_r (rr_w[k]),
                .res_out_i (ri_w[k]),
                .fin       (fin_w[k])
            );
        end
    endgenerate

    assign bin_real = rr_w[0];
    assign bin_imag = ri_w[0];
    assign bin_last = (cnt_reg == LOG2N'(POINTS - 1));

endmodule

### src/dft_cell.sv
module dft_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int LOG2N       = 6,
    parameter int STEP        = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dft_pkg::tok_ctl_t                      in_ctl,
    input  logic signed [SAMPLE_BITS-1:0]          in_xr,
    input  logic signed [SAMPLE_BITS-1:0]          in_xi,
    input  logic                                   inverse,
    input  logic                                   shift_en,
    input  logic signed [dft_pkg::BIN_BITS-1:0]    res_in_r,
    input  logic signed [dft_pkg::BIN_BITS-1:0]    res_in_i,
    output dft_pkg::tok_ctl_t                      out_ctl,
    output logic signed [SAMPLE_BITS-1:0]          out_xr,
    output logic signed [SAMPLE_BITS-1:0]          out_xi,
    output logic signed [dft_pkg::BIN_BITS-1:0]    res_out_r,
    output logic signed [dft_pkg::BIN_BITS-1:0]    res_out_i,
    output logic                                   fin
);
    import dft_pkg::*;

    localparam int PW   = SAMPLE_BITS + TWIDDLE_BITS;
    localparam int ACCW = PW + LOG2N;
    localparam int SUMW = ACCW + 2;

    tok_ctl_t                   ctl_reg;
    logic signed [SAMPLE_BITS-1:0] xr_reg, xi_reg;
    phase_t                     phase_reg;
    logic                       fin_reg;
    logic signed [ACCW-1:0]     acc_a_reg, acc_b_reg, acc_c_reg, acc_d_reg;
    logic signed [BIN_BITS-1:0] res_r_reg, res_i_reg;

    phase_t                     phase_use;
    twiddle_t                   c, s;
    logic signed [PW-1:0]       pa, pb, pc, pd;
    logic signed [SUMW-1:0]     sum_r, sum_i, rnd_r, rnd_i;
    logic signed [BIN_BITS-1:0] sat_r, sat_i;

    // Phase of sample n in bin k is n*k*stride, built up one step per token.
    assign phase_use = in_ctl.first ? '0 : phase_reg;
    assign c  = cos_at(phase_use);
    assign s  = sin_at(phase_use);
    assign pa = in_xr * c;
    assign pb = in_xi * s;
    assign pc = in_xi * c;
    assign pd = in_xr * s;

    always_comb
    begin
        if (inverse)
        begin
            sum_r = SUMW'(acc_a_reg) - SUMW'(acc_b_reg);
            sum_i = SUMW'(acc_c_reg) + SUMW'(acc_d_reg);
            rnd_r = (sum_r + (SUMW'(1) <<< (14 + LOG2N))) >>> (15 + LOG2N);
            rnd_i = (sum_i + (SUMW'(1) <<< (14 + LOG2N))) >>> (15 + LOG2N);
        end
        else
        begin
            sum_r = SUMW'(acc_a_reg) + SUMW'(acc_b_reg);
            sum_i = SUMW'(acc_c_reg) - SUMW'(acc_d_reg);
            rnd_r = (sum_r + (SUMW'(1) <<< 14)) >>> 15;
            rnd_i = (sum_i + (SUMW'(1) <<< 14)) >>> 15;
        end
        if (rnd_r > SUMW'(OUT_MAX))
            sat_r = BIN_BITS'(OUT_MAX);
        else if (rnd_r < SUMW'(OUT_MIN))
            sat_r = BIN_BITS'(OUT_MIN);
        else
            sat_r = rnd_r[BIN_BITS-1:0];
        if (rnd_i > SUMW'(OUT_MAX))
            sat_i = BIN_BITS'(OUT_MAX);
        else if (rnd_i < SUMW'(OUT_MIN))
            sat_i = BIN_BITS'(OUT_MIN);
        else
            sat_i = rnd_i[BIN_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            fin_reg   <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
            fin_reg <= in_ctl.valid & in_ctl.last;
            if (in_ctl.valid)
                phase_reg <= phase_use + phase_t'(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        xr_reg <= in_xr;
        xi_reg <= in_xi;
        if (in_ctl.valid)
        begin
            if (in_ctl.first)
            begin
                acc_a_reg <= ACCW'(pa);
                acc_b_reg <= ACCW'(pb);
                acc_c_reg <= ACCW'(pc);
                acc_d_reg <= ACCW'(pd);
            end
            else
            begin
                acc_a_reg <= acc_a_reg + ACCW'(pa);
                acc_b_reg <= acc_b_reg + ACCW'(pb);
                acc_c_reg <= acc_c_reg + ACCW'(pc);
                acc_d_reg <= acc_d_reg + ACCW'(pd);
            end
        end
        if (fin_reg)
        begin
            res_r_reg <= sat_r;
            res_i_reg <= sat_i;
        end
        else if (shift_en)
        begin
            res_r_reg <= res_in_r;
            res_i_reg <= res_in_i;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_xr    = xr_reg;
    assign out_xi    = xi_reg;
    assign res_out_r = res_r_reg;
    assign res_out_i = res_i_reg;
    assign fin       = fin_reg;

endmodule
